>>> hw/rtl/vvho_pkg.sv
// Shared types and constants for the ventilation valve controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package vvho_pkg;

   // Command codes of an input transaction.
   typedef enum logic [1:0] {
      CMD_EVALUATE = 2'd0,
      CMD_FORCE    = 2'd1,
      CMD_UNFORCE  = 2'd2
   } cmd_type;

   // Valve movement reported with a result.
   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_OPENED = 2'd1,
      ACT_CLOSED = 2'd2
   } action_type;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HYSTERESIS   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_INTERVAL = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [6:0]  HYSTERESIS_RESET   = 7'd3;
   localparam logic [15:0] MIN_INTERVAL_RESET = 16'd60;

   // Sensor code that marks a reading as unknown.
   localparam logic signed [7:0] UNKNOWN_TEMP = -8'sd127;

   typedef struct packed {
      cmd_type            cmd;
      logic [31:0]        now_sec;
      logic signed [7:0]  temp_inside;
      logic signed [7:0]  temp_outside;
      logic               force_open;
      logic               force_timed;
      logic [30:0]        force_duration_sec;
   } req_type;

   typedef struct packed {
      logic       valve_open;
      logic       override_active;
      logic       override_permanent;
      action_type valve_action;
      logic       override_ended;
      logic       readings_invalid;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/vvho_in_stage.sv
// Input register of the valve controller: captures one request transaction.
// Depends on vvho_pkg for the request type.
`default_nettype none

module vvho_in_stage import vvho_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    advance,
   output logic         item_valid,
   output req_type      item
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;

   // The held transaction blocks new ones until the core consumes it.
   assign req_stall = valid_ff && !advance;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         if (req_valid) begin
            data_in = req_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/vvho_core.sv
// Valve state, override state and configuration registers, with the
// single-pass decision logic. Depends on vvho_pkg.
`default_nettype none

module vvho_core import vvho_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  wire logic                       advance,
   input  wire req_type                    item,
   output rsp_type                         result
);

   logic [6:0]  hyst_ff, hyst_in;
   logic [15:0] min_int_ff, min_int_in;
   logic        valve_ff, valve_in;
   logic        ovr_ff, ovr_in;
   logic        forever_ff, forever_in;
   logic [31:0] until_ff, until_in;
   logic [31:0] last_ff, last_in;

   logic              forced;
   logic [31:0]       elapsed;
   logic signed [8:0] t_in9;
   logic signed [8:0] t_out9;
   logic signed [8:0] open_level;
   logic              do_toggle;
   action_type        action;
   logic              ended;
   logic              invalid;

   always_comb begin
      hyst_in    = hyst_ff;
      min_int_in = min_int_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_HYSTERESIS:   hyst_in    = csr_wdata[6:0];
            CSR_MIN_INTERVAL: min_int_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      t_in9      = {item.temp_inside[7], item.temp_inside};
      t_out9     = {item.temp_outside[7], item.temp_outside};
      open_level = t_out9 + $signed({2'b00, hyst_ff});
      elapsed    = (item.now_sec >= last_ff) ? (item.now_sec - last_ff)
                                              : (last_ff - item.now_sec);
      forced     = ovr_ff && (forever_ff || (item.now_sec < until_ff));

      valve_in   = valve_ff;
      ovr_in     = ovr_ff;
      forever_in = forever_ff;
      until_in   = until_ff;
      last_in    = last_ff;
      do_toggle  = 1'b0;
      ended      = 1'b0;
      invalid    = 1'b0;

      case (item.cmd)
         CMD_EVALUATE: begin
            if (ovr_ff && !forced) begin
               ovr_in = 1'b0;
               ended  = 1'b1;
            end
            if (!forced && (elapsed >= {16'd0, min_int_ff})) begin
               if (item.temp_inside == UNKNOWN_TEMP || item.temp_outside == UNKNOWN_TEMP) begin
                  invalid = 1'b1;
               end else if (valve_ff) begin
                  do_toggle = (t_in9 <= t_out9);
               end else begin
                  do_toggle = (t_in9 >= open_level);
               end
            end
         end
         CMD_FORCE: begin
            ovr_in     = 1'b1;
            forever_in = !item.force_timed;
            until_in   = item.force_timed ? (item.now_sec + {1'b0, item.force_duration_sec})
                                          : 32'd0;
            do_toggle  = (valve_ff != item.force_open);
         end
         CMD_UNFORCE: begin
            ovr_in     = 1'b0;
            forever_in = 1'b0;
         end
         default: ;
      endcase

      action = ACT_NONE;
      if (do_toggle) begin
         valve_in = !valve_ff;
         last_in  = item.now_sec;
         action   = valve_ff ? ACT_CLOSED : ACT_OPENED;
      end

      result.valve_open         = valve_in;
      result.override_active    = ovr_in;
      result.override_permanent = forever_in;
      result.valve_action       = action;
      result.override_ended     = ended;
      result.readings_invalid   = invalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff    <= HYSTERESIS_RESET;
         min_int_ff <= MIN_INTERVAL_RESET;
         valve_ff   <= 1'b0;
         ovr_ff     <= 1'b0;
         forever_ff <= 1'b0;
         until_ff   <= 32'd0;
         last_ff    <= 32'd0;
      end else begin
         hyst_ff    <= hyst_in;
         min_int_ff <= min_int_in;
         if (advance) begin
            valve_ff   <= valve_in;
            ovr_ff     <= ovr_in;
            forever_ff <= forever_in;
            until_ff   <= until_in;
            last_ff    <= last_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/vvho_out_stage.sv
// Result register of the valve controller: holds one response transaction.
// Depends on vvho_pkg for the response type.
`default_nettype none

module vvho_out_stage import vvho_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type result,
   output logic         can_load,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // Room for a new result when empty or when the held one leaves now.
   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (can_load) begin
         valid_in = load;
         if (load) begin
            data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/vent_valve_hysteresis_override_top.sv
// Top level of the ventilation valve controller with hysteresis and override.
// Depends on vvho_pkg, vvho_in_stage, vvho_core and vvho_out_stage.
`default_nettype none

// The controller takes one command transaction per clock cycle while the
// response side does not stall and returns exactly one response transaction
// for each, in order. A request is captured in an input register; the
// decision logic reads it together with the valve and override state and,
// when the output register has room, updates that state and loads the
// response into the output register, which offers it. Sustained throughput
// is one transaction per cycle while the response side does not stall; the
// decision logic is a single combinational pass (a 32-bit distance and
// compare for the switch interval, a 32-bit end-time compare, and a 32-bit
// add for a timed override). When the response side stalls, the output
// register holds its result and the input register holds the next request,
// and req_stall stays high meanwhile. Configuration writes are always ready
// and take effect at the next edge; write them only while no transaction is
// in flight. Register 0 is the hysteresis in degrees (7 bits, reset 3) and
// register 1 the minimum interval between automatic switches in seconds
// (16 bits, reset 60).
module vent_valve_hysteresis_override_top import vvho_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_type                    req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic    item_valid;
   req_type item;
   logic    can_load;
   logic    advance;
   rsp_type result;

   // The configuration registers accept a write in any cycle.
   assign csr_ready = 1'b1;

   // A captured request is processed when the result register has room.
   assign advance = item_valid && can_load;

   vvho_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   vvho_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .item      (item),
      .result    (result)
   );

   vvho_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> hw/rtl/vvho_checker.sv
// Port-level checks for the valve controller, bound to the top level.
// Depends on vvho_pkg and vent_valve_hysteresis_override_top.
`default_nettype none

module vvho_checker import vvho_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A stalled response stays and keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // An opening move leaves the valve open, a closing move leaves it closed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.valve_action == ACT_OPENED) |-> rsp_data.valve_open)
      else $error("valve opened but reported closed");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.valve_action == ACT_CLOSED) |-> !rsp_data.valve_open)
      else $error("valve closed but reported open");

   // An expired override is no longer active.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.override_ended |-> !rsp_data.override_active)
      else $error("override ended but still active");

   // A response that flags unknown readings reports no valve movement.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.readings_invalid |-> (rsp_data.valve_action == ACT_NONE))
      else $error("valve moved on unknown readings");

endmodule

bind vent_valve_hysteresis_override_top vvho_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
